// ===== rtl/kdb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kdb_pkg
// shared types, widths and the key code table of the keypad debouncer
// ----------------------------------------------------------------------------
package kdb_pkg;

	localparam int CNT_W  = 8;
	localparam int CODE_W = 7;
	localparam int IDX_W  = 2;

	localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd3;

	localparam logic KIND_PRESS   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// what one key lane found during a scan
	typedef struct packed {
		logic hit;
		logic kind;
	} lane_evt_t;

	// ascii digit of a key, zero outside the 3x3 table
	function automatic logic [CODE_W-1:0] code_of(input int r, input int c);
		logic [CODE_W-1:0] code;
		code = '0;
		if (r >= 0 && r < 3 && c >= 0 && c < 3) begin
			code = CODE_W'(8'h33 + 8'(3 * r) - 8'(c));
		end
		return code;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/kdb_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kdb_lane
// integrating debounce counter and stable flag for one key
// ----------------------------------------------------------------------------
module kdb_lane (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      scan_load,
	input  wire                      level,
	input  wire [kdb_pkg::CNT_W-1:0] threshold,
	output kdb_pkg::lane_evt_t       evt
);
	import kdb_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             released_q;
	logic [CNT_W-1:0] count_nxt;

	always_comb begin
		if (!level) begin
			count_nxt = (count_q < threshold) ? count_q + CNT_W'(1) : count_q;
			evt.hit   = (count_nxt == threshold) && released_q;
			evt.kind  = KIND_PRESS;
		end else begin
			count_nxt = (count_q != '0) ? count_q - CNT_W'(1) : count_q;
			evt.hit   = (count_nxt == '0) && !released_q;
			evt.kind  = KIND_RELEASE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			released_q <= 1'b1;
		end else if (scan_load) begin
			count_q <= count_nxt;
			if (evt.hit) begin
				released_q <= (evt.kind == KIND_RELEASE);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kdb_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kdb_merge
// collects lane events of a scan and serializes them in column-major order
// ----------------------------------------------------------------------------
module kdb_merge #(
	parameter int ROWS = 3,
	parameter int COLS = 3
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     scan_load,
	input  kdb_pkg::lane_evt_t [ROWS*COLS-1:0]      lane_evt,
	output logic                                    scan_ready,
	output logic                                    out_valid,
	input  wire                                     out_stall,
	output logic [kdb_pkg::IDX_W-1:0]               event_row,
	output logic [kdb_pkg::IDX_W-1:0]               event_col,
	output logic                                    event_kind,
	output logic [kdb_pkg::CODE_W-1:0]              key_code,
	output logic                                    last
);
	import kdb_pkg::*;

	localparam int NK = ROWS * COLS;

	logic [NK-1:0]     pend_mask_q;
	logic [NK-1:0]     pend_kind_q;
	logic [NK-1:0]     sel_onehot;
	logic [NK-1:0]     rest_mask;
	logic [IDX_W-1:0]  sel_row;
	logic [IDX_W-1:0]  sel_col;
	logic              sel_kind;
	logic [CODE_W-1:0] sel_code;
	logic              found;
	logic              pop;
	logic              rest_empty;

	logic              out_valid_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic              kind_q;
	logic [CODE_W-1:0] code_q;
	logic              last_q;

	// lowest pending lane first; lanes are already in column-major order
	always_comb begin
		found      = 1'b0;
		sel_onehot = '0;
		sel_row    = '0;
		sel_col    = '0;
		sel_kind   = 1'b0;
		sel_code   = '0;
		for (int i = 0; i < NK; i++) begin
			if (!found && pend_mask_q[i]) begin
				found         = 1'b1;
				sel_onehot[i] = 1'b1;
				sel_row       = IDX_W'(i % ROWS);
				sel_col       = IDX_W'(i / ROWS);
				sel_kind      = pend_kind_q[i];
				sel_code      = code_of(i % ROWS, i / ROWS);
			end
		end
	end

	assign rest_mask  = pend_mask_q & ~sel_onehot;
	assign rest_empty = (rest_mask == '0);
	assign pop        = found && (!out_valid_q || !out_stall);
	assign scan_ready = !found || (pop && rest_empty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_mask_q <= '0;
		end else if (scan_load) begin
			for (int i = 0; i < NK; i++) begin
				pend_mask_q[i] <= lane_evt[i].hit;
			end
		end else if (pop) begin
			pend_mask_q <= rest_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_load) begin
			for (int i = 0; i < NK; i++) begin
				pend_kind_q[i] <= lane_evt[i].kind;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			row_q  <= sel_row;
			col_q  <= sel_col;
			kind_q <= sel_kind;
			code_q <= sel_code;
			last_q <= rest_empty;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_row  = row_q;
	assign event_col  = col_q;
	assign event_kind = kind_q;
	assign key_code   = code_q;
	assign last       = last_q;

	// a new scan never overwrites events still waiting to go out
	a_load_safe: assert property (@(posedge clk) disable iff (!arst_n)
		scan_load |-> (pend_mask_q == '0) || (pop && rest_empty))
		else $error("scan loaded over pending events");

	// the last marker follows whether the popped event drained the scan
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (last_q == $past(rest_empty)))
		else $error("last marker does not match drained scan");

	// a shown beat only leaves when the receiver takes it
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled event dropped");

	// pending work always implies a selected event
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_mask_q != '0) |-> ($countones(sel_onehot) == 1))
		else $error("pending events but no selection");

endmodule
`default_nettype wire

// ===== rtl/keypad_matrix_debouncer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_matrix_debouncer_core
// integrating debouncer for a key matrix with serialized press/release events
// ----------------------------------------------------------------------------
// usage
//   scan channel: in_valid / in_stall with key_levels, one bit per key at
//     row*COLS+col, low = pressed. a scan is taken when in_valid && !in_stall
//   event channel: out_valid / out_stall with event_row, event_col,
//     event_kind (0 press, 1 release), key_code and last. a beat moves when
//     out_valid && !out_stall; last marks the final event of a scan
//   config channel: cfg_valid / cfg_ready with cfg_data, the debounce
//     threshold. cfg_ready is always high; write only while idle
//   timing: all key lanes update in the accept cycle; the first event of a
//     scan waits in the pending mask, then moves into the output register
//   throughput: one event beat per cycle while out_stall is low, set by the
//     single output register fed from the event merger. a scan holds up to
//     ROWS*COLS events, one per key; the next scan is taken in the cycle the
//     previous scan's final event moves into the output register
//   stall: while out_stall holds, the shown event stays put and pending
//     events wait; in_stall is high while events remain after this cycle
//   reset: counters clear, all keys released, threshold back to 3, no
//     events pending
// ----------------------------------------------------------------------------
module keypad_matrix_debouncer_core #(
	parameter int ROWS = 3,
	parameter int COLS = 3
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// scan beats
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [ROWS*COLS-1:0]         key_levels,
	// event beats
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [kdb_pkg::IDX_W-1:0]    event_row,
	output logic [kdb_pkg::IDX_W-1:0]    event_col,
	output logic                         event_kind,
	output logic [kdb_pkg::CODE_W-1:0]   key_code,
	output logic                         last,
	// threshold writes
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [kdb_pkg::CNT_W-1:0]    cfg_data
);
	import kdb_pkg::*;

	localparam int NK = ROWS * COLS;

	logic [CNT_W-1:0]     threshold_q;
	logic                 scan_ready;
	logic                 scan_load;
	lane_evt_t [NK-1:0]   lane_evt;

	// threshold register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	// scan is taken whenever the merger can hold its events
	assign in_stall  = !scan_ready;
	assign scan_load = in_valid && scan_ready;

	// one lane per key, placed in column-major order so the merger
	// can pick the lowest pending lane first
	for (genvar j = 0; j < NK; j++) begin : g_lane
		localparam int R = j % ROWS;
		localparam int C = j / ROWS;
		kdb_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.scan_load (scan_load),
			.level     (key_levels[R*COLS + C]),
			.threshold (threshold_q),
			.evt       (lane_evt[j])
		);
	end

	// merge lane findings into one event beat per cycle while out_stall is low
	kdb_merge #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_load  (scan_load),
		.lane_evt   (lane_evt),
		.scan_ready (scan_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_row  (event_row),
		.event_col  (event_col),
		.event_kind (event_kind),
		.key_code   (key_code),
		.last       (last)
	);

endmodule
`default_nettype wire

// ===== test/keypad_matrix_debouncer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_matrix_debouncer_core_test
// self-checking bench for the 3x3 keypad debouncer: scan beats go in with
// random gaps, event beats come out under random stall, and every event is
// compared field by field against a scan-by-scan debounce predictor
// ----------------------------------------------------------------------------
module keypad_matrix_debouncer_core_test;
	import kdb_pkg::*;

	localparam int ROWS = 3;
	localparam int COLS = 3;
	localparam int KEYS = ROWS * COLS;

	// cycles that may pass after the last event before the core is surely idle
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 20;

	localparam int RANDOM_PHASES   = 6;
	localparam int SCANS_PER_PHASE = 43;
	// phase whose threshold is drawn at random instead of taken from the list
	localparam int DRAWN_PHASE     = 4;
	// phase that holds the scan feed until every pending event has drained
	localparam int DRAIN_PHASE     = 2;

	localparam logic [KEYS-1:0] ALL_UP   = '1;
	localparam logic [KEYS-1:0] ALL_DOWN = '0;

	// ascii digit of each key, indexed row*COLS+col
	localparam logic [CODE_W-1:0] DIGIT [KEYS] = '{
		7'h33, 7'h32, 7'h31,  // '3' '2' '1'
		7'h36, 7'h35, 7'h34,  // '6' '5' '4'
		7'h39, 7'h38, 7'h37   // '9' '8' '7'
	};

	typedef struct packed {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              kind;
		logic [CODE_W-1:0] code;
		logic              last;
	} key_beat_t;

	localparam key_beat_t NO_EVENT = '0;

	typedef enum logic [1:0] {
		STEP_SCAN,       // events worked out by the predictor
		STEP_QUIET,      // scan must cause no event at all
		STEP_ONE,        // scan causes exactly the event typed in the row
		STEP_THRESHOLD   // write the debounce threshold
	} step_op_e;

	typedef struct packed {
		step_op_e          op;
		logic [KEYS-1:0]   levels;
		logic [CNT_W-1:0]  value;
		key_beat_t         one;
	} step_t;

	// directed opening: reset state, one key through press and release,
	// threshold 1 with all keys at once, threshold 255 (nothing confirms),
	// then a threshold dropped below the running counters
	localparam int SCRIPT_LEN = 25;
	localparam step_t SCRIPT [SCRIPT_LEN] = '{
		'{STEP_QUIET,     ALL_UP,   8'd0,   NO_EVENT},
		'{STEP_QUIET,     9'h1FE,   8'd0,   NO_EVENT},
		'{STEP_QUIET,     9'h1FE,   8'd0,   NO_EVENT},
		'{STEP_ONE,       9'h1FE,   8'd0,   '{2'd0, 2'd0, KIND_PRESS, 7'h33, 1'b1}},
		'{STEP_QUIET,     ALL_UP,   8'd0,   NO_EVENT},
		'{STEP_QUIET,     ALL_UP,   8'd0,   NO_EVENT},
		'{STEP_ONE,       ALL_UP,   8'd0,   '{2'd0, 2'd0, KIND_RELEASE, 7'h33, 1'b1}},
		'{STEP_THRESHOLD, ALL_UP,   8'd1,   NO_EVENT},
		'{STEP_SCAN,      ALL_DOWN, 8'd0,   NO_EVENT},
		'{STEP_SCAN,      ALL_UP,   8'd0,   NO_EVENT},
		'{STEP_ONE,       9'h0FF,   8'd0,   '{2'd2, 2'd2, KIND_PRESS, 7'h37, 1'b1}},
		'{STEP_SCAN,      9'h1FE,   8'd0,   NO_EVENT},
		'{STEP_SCAN,      ALL_UP,   8'd0,   NO_EVENT},
		'{STEP_THRESHOLD, ALL_UP,   8'd255, NO_EVENT},
		'{STEP_QUIET,     ALL_DOWN, 8'd0,   NO_EVENT},
		'{STEP_QUIET,     ALL_DOWN, 8'd0,   NO_EVENT},
		'{STEP_QUIET,     ALL_DOWN, 8'd0,   NO_EVENT},
		'{STEP_QUIET,     ALL_DOWN, 8'd0,   NO_EVENT},
		'{STEP_THRESHOLD, ALL_UP,   8'd2,   NO_EVENT},
		'{STEP_QUIET,     ALL_DOWN, 8'd0,   NO_EVENT},
		'{STEP_QUIET,     ALL_UP,   8'd0,   NO_EVENT},
		'{STEP_QUIET,     ALL_UP,   8'd0,   NO_EVENT},
		'{STEP_SCAN,      ALL_DOWN, 8'd0,   NO_EVENT},
		'{STEP_QUIET,     ALL_UP,   8'd0,   NO_EVENT},
		'{STEP_SCAN,      ALL_UP,   8'd0,   NO_EVENT}
	};

	localparam logic [CNT_W-1:0] PHASE_THRESHOLD [RANDOM_PHASES] = '{
		8'd3, 8'd1, 8'd2, 8'd255, 8'd0, 8'd4
	};
	// phase 0 runs with no idling at all on either side
	localparam int PHASE_GAP_PCT   [RANDOM_PHASES] = '{0, 30, 60, 20, 40, 10};
	localparam int PHASE_STALL_PCT [RANDOM_PHASES] = '{0, 30, 10, 20, 60, 45};

	// dut ports; the driven inputs are all known from time zero
	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [KEYS-1:0]     key_levels = ALL_UP;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [IDX_W-1:0]    event_row;
	logic [IDX_W-1:0]    event_col;
	logic                event_kind;
	logic [CODE_W-1:0]   key_code;
	logic                last;
	logic                cfg_valid  = 1'b0;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data   = THRESHOLD_RESET;

	// how the scan on the bus is to be checked, moves with the scan beat
	step_op_e            scan_note     = STEP_SCAN;
	key_beat_t           scan_note_evt = NO_EVENT;

	// predictor state
	logic [CNT_W-1:0]    key_count    [KEYS];
	logic                key_up       [KEYS];
	logic [CNT_W-1:0]    threshold_now;
	key_beat_t           pending_events [$];

	int                  failures     = 0;
	int                  scans_taken  = 0;
	int                  events_seen  = 0;
	int                  thr_writes   = 0;
	int                  idle_cycles  = 0;
	int                  gap_pct      = 0;
	int                  stall_pct    = 0;
	int                  stall_left   = 0;
	key_beat_t           want_evt;

	keypad_matrix_debouncer_core #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key_levels (key_levels),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_row  (event_row),
		.event_col  (event_col),
		.event_kind (event_kind),
		.key_code   (key_code),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle length: mostly short, now and then a long stretch
	function automatic int idle_length();
		if ($urandom_range(99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// one scan through the debounce counters, column outer and row inner;
	// the events are queued only when publish is set, the state moves always
	function automatic void debounce_scan(input logic [KEYS-1:0] levels, input logic publish);
		key_beat_t  found [$];
		int         k;
		for (int c = 0; c < COLS; c++) begin
			for (int r = 0; r < ROWS; r++) begin
				k = r * COLS + c;
				if (!levels[k]) begin
					// line low: integrate toward the threshold, saturating there
					if (key_count[k] < threshold_now) begin
						key_count[k] = key_count[k] + 1'b1;
					end
					if (key_count[k] == threshold_now && key_up[k]) begin
						key_up[k] = 1'b0;
						found.push_back('{IDX_W'(r), IDX_W'(c), KIND_PRESS, DIGIT[k], 1'b0});
					end
				end else begin
					// line high: integrate back toward zero
					if (key_count[k] > 0) begin
						key_count[k] = key_count[k] - 1'b1;
					end
					if (key_count[k] == 0 && !key_up[k]) begin
						key_up[k] = 1'b1;
						found.push_back('{IDX_W'(r), IDX_W'(c), KIND_RELEASE, DIGIT[k], 1'b0});
					end
				end
			end
		end
		if (found.size() > 0) begin
			found[found.size() - 1].last = 1'b1;
		end
		if (publish) begin
			foreach (found[i]) begin
				pending_events.push_back(found[i]);
			end
		end
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			failures++;
			if (failures <= REPORT_LIMIT) begin
				$display("%0t: %s wrong, expected %0d, actual %0d", $time, name, want, got);
			end
		end
	endtask

	// scoreboard: every signal is read as it stood before this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				threshold_now = cfg_data;
				thr_writes++;
			end
			// events first: a scan taken at this edge cannot have an event out yet
			if (out_valid && !out_stall) begin
				events_seen++;
				if (pending_events.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("%0t: event beat with none expected, actual row %0d col %0d kind %0d code %h last %0d",
							$time, event_row, event_col, event_kind, key_code, last);
					end
				end else begin
					want_evt = pending_events.pop_front();
					check_field("event_row", want_evt.row, event_row);
					check_field("event_col", want_evt.col, event_col);
					check_field("event_kind", want_evt.kind, event_kind);
					check_field("key_code", want_evt.code, key_code);
					check_field("last", want_evt.last, last);
				end
			end
			if (in_valid && !in_stall) begin
				scans_taken++;
				debounce_scan(key_levels, scan_note == STEP_SCAN);
				if (scan_note == STEP_ONE) begin
					pending_events.push_back(scan_note_evt);
				end
			end
		end
	end

	// watchdog: a stretch with no beat on any channel means the core hung
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d events still expected",
				$time, WATCHDOG_LIMIT, pending_events.size());
			$display("keypad_matrix_debouncer_core: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// event side back-pressure: random stall stretches at the phase's rate
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_left = idle_length() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// one scan beat; holds until taken, then maybe leaves a gap
	task automatic send_scan(input logic [KEYS-1:0] levels, input step_op_e note,
			input key_beat_t one);
		in_valid      <= 1'b1;
		key_levels    <= levels;
		scan_note     <= note;
		scan_note_evt <= one;
		do @(posedge clk); while (in_stall);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat (idle_length()) @(posedge clk);
		end
	endtask

	// hold the scan feed until every expected event has come out, then let
	// a scan that caused no event finish inside the core
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [CNT_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [KEYS-1:0]  held;
		logic [KEYS-1:0]  levels;
		logic [CNT_W-1:0] thr;
		int               bounce_pct;

		// predictor comes up the way the core leaves reset
		threshold_now = THRESHOLD_RESET;
		for (int k = 0; k < KEYS; k++) begin
			key_count[k] = '0;
			key_up[k]    = 1'b1;
		end
		held       = ALL_UP;
		bounce_pct = 4;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening with light idling
		gap_pct = 20;
		stall_pct <= 20;
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (SCRIPT[i].op == STEP_THRESHOLD) begin
				write_threshold(SCRIPT[i].value);
			end else begin
				send_scan(SCRIPT[i].levels, SCRIPT[i].op, SCRIPT[i].one);
			end
		end

		// random phases: keys are held pressed or released for stretches with
		// some contact bounce on top, plus a share of raw noise scans
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			thr = (phase == DRAWN_PHASE) ? CNT_W'($urandom_range(5, 12)) : PHASE_THRESHOLD[phase];
			write_threshold(thr);
			gap_pct = PHASE_GAP_PCT[phase];
			stall_pct <= PHASE_STALL_PCT[phase];
			for (int n = 0; n < SCANS_PER_PHASE; n++) begin
				if (phase == DRAIN_PHASE && n == SCANS_PER_PHASE / 2) begin
					wait_idle();
				end
				if ($urandom_range(99) < 10) begin
					levels = KEYS'($urandom);
				end else begin
					if ($urandom_range(99) < 30) begin
						held[$urandom_range(KEYS - 1)] ^= 1'b1;
					end
					levels = held;
					for (int k = 0; k < KEYS; k++) begin
						if ($urandom_range(99) < bounce_pct) begin
							levels[k] = ~levels[k];
						end
					end
				end
				send_scan(levels, STEP_SCAN, NO_EVENT);
			end
		end

		// drain everything still in flight
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_events.size() != 0) begin
			failures++;
			$display("%0t: %0d events expected but never seen", $time, pending_events.size());
		end
		$display("covered %0d scans, %0d key events, %0d threshold writes from 1 to 255,",
			scans_taken, events_seen, thr_writes);
		$display("with random scan gaps and event stalls, %0d field errors", failures);
		if (failures == 0) begin
			$display("keypad_matrix_debouncer_core: match");
		end else begin
			$display("keypad_matrix_debouncer_core: mismatch");
		end
		$finish;
	end

endmodule
